### hw/rtl/crlvt_pkg.sv
package crlvt_pkg;

  localparam int FrameBytes = 8;
  localparam int IdW        = 11;
  localparam int LenW       = 4;
  localparam int PayloadW   = 8 * FrameBytes;
  localparam int StampW     = 32;
  localparam int StatusW    = 3;
  localparam int InDataW    = 112;
  localparam int OutDataW   = 104;

  typedef enum logic [StatusW-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_NOMATCH,
    S_RESP
  } state_e;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic [StampW-1:0]   stamp;
    logic [PayloadW-1:0] payload;
    logic [LenW-1:0]     len;
    logic [IdW-1:0]      ident;
  } entry_t;

  typedef struct packed {
    status_e             status;
    logic [StampW-1:0]   stamp;
    logic [PayloadW-1:0] payload;
    logic [LenW-1:0]     len;
  } result_t;

  function automatic logic [PayloadW-1:0] merge_payload(
    input logic [PayloadW-1:0] old_p,
    input logic [PayloadW-1:0] new_p,
    input logic [LenW-1:0]     len
  );
    logic [PayloadW-1:0] p;
    p = old_p;
    for (int b = 0; b < FrameBytes; b++) begin
      if (LenW'(b) < len) begin
        p[8*b +: 8] = new_p[8*b +: 8];
      end
    end
    return p;
  endfunction

endpackage

### hw/rtl/can_rx_last_value_table.sv
// Channel  Dir  tdata (low bit up)                                  tuser
// s_axis   in   msg_id, frame_len, data_byte0..data_byte7, now_tick  operation
// m_axis   out  stored_len, out_byte0..out_byte7, stored_tick        status
//
// An item walks the filled entries in order, a read state and a compare state
// for each, until an identifier matches or the fill count is reached; the single-port
// entry memory and its one identifier comparator set this pace.
// Entries fill from index 0 upward and are never freed, so a fill count
// stands for the valid bits; reset clears it at once, no clearing pass.
// A finished result waits in the output register while the next item is taken.
module can_rx_last_value_table
  import crlvt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // msg_id, frame_len, data_byte0..data_byte7, now_tick, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // stored_len, out_byte0..out_byte7, stored_tick, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [StatusW-1:0]  m_axis_tuser
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  op_e                 op_q;
  logic [IdW-1:0]      id_q;
  logic [LenW-1:0]     len_q;
  logic [PayloadW-1:0] data_q;
  logic [StampW-1:0]   tick_q;
  result_t             res_q, res_d;
  logic                m_valid_q;
  result_t             m_res_q;

  entry_t              mem_q [TABLE_ENTRIES];
  entry_t              rdata_q;
  logic                mem_we;
  logic [IdxW-1:0]     mem_wa;
  entry_t              mem_wd;
  entry_t              upd_entry, ins_entry;
  logic                in_xfer, out_load;
  logic [LenW-1:0]     in_len;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_len        = (s_axis_tdata[14:11] > LenW'(FrameBytes)) ?
                         LenW'(FrameBytes) : s_axis_tdata[14:11];

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_e'(s_axis_tuser);
      id_q   <= s_axis_tdata[10:0];
      len_q  <= in_len;
      data_q <= s_axis_tdata[78:15];
      tick_q <= s_axis_tdata[110:79];
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[idx_q[IdxW-1:0]];
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_comb begin
    upd_entry         = rdata_q;
    upd_entry.payload = merge_payload(rdata_q.payload, data_q, len_q);
    upd_entry.len     = len_q;
    upd_entry.stamp   = tick_q;
    ins_entry.ident   = id_q;
    ins_entry.payload = merge_payload('0, data_q, len_q);
    ins_entry.len     = len_q;
    ins_entry.stamp   = tick_q;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    mem_we   = 1'b0;
    mem_wa   = idx_q[IdxW-1:0];
    mem_wd   = upd_entry;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d   = '0;
          state_d = (cnt_q == '0) ? S_NOMATCH : S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata_q.ident == id_q) begin
          state_d = S_RESP;
          if (op_q == OP_LOOKUP) begin
            res_d = '{status: ST_HIT, stamp: rdata_q.stamp,
                      payload: rdata_q.payload, len: rdata_q.len};
          end else begin
            mem_we = 1'b1;
            res_d  = '{status: ST_UPDATED, stamp: upd_entry.stamp,
                       payload: upd_entry.payload, len: upd_entry.len};
          end
        end else if (CntW'(idx_q + 1'b1) == cnt_q) begin
          state_d = S_NOMATCH;
        end else begin
          idx_d   = CntW'(idx_q + 1'b1);
          state_d = S_READ;
        end
      end
      S_NOMATCH: begin
        state_d = S_RESP;
        if (op_q == OP_LOOKUP) begin
          res_d = '{status: ST_MISS, stamp: '0, payload: '0, len: '0};
        end else if (cnt_q == CntW'(TABLE_ENTRIES)) begin
          res_d = '{status: ST_DROPPED, stamp: '0, payload: '0, len: '0};
        end else begin
          mem_we = 1'b1;
          mem_wa = cnt_q[IdxW-1:0];
          mem_wd = ins_entry;
          cnt_d  = CntW'(cnt_q + 1'b1);
          res_d  = '{status: ST_INSERTED, stamp: ins_entry.stamp,
                     payload: ins_entry.payload, len: ins_entry.len};
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      m_res_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {4'b0, m_res_q.stamp, m_res_q.payload, m_res_q.len};

endmodule

### hw/rtl/crlvt_checker.sv
module crlvt_checker
  import crlvt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ST_MISS)
    else $error("undefined status code");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_DROPPED || m_axis_tuser == ST_MISS)
    |-> m_axis_tdata == '0)
    else $error("drop or miss carries entry data");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[LenW-1:0] <= LenW'(FrameBytes))
    else $error("stored length above frame size");

endmodule

bind can_rx_last_value_table crlvt_checker u_crlvt_checker (.*);

### dv/tb_can_rx_last_value_table.sv
`timescale 1ns / 100ps

module tb_can_rx_last_value_table;
  import crlvt_pkg::*;

  localparam int Entries    = 32;
  localparam int NumDir     = 18;
  localparam int NumRandom  = 500;
  localparam int PoolSize   = 48;
  localparam int QuietLimit = 4000;
  localparam int DrainWait  = 2 * Entries + 16;
  localparam int HoldOffAt  = 200;
  localparam int HoldOffLen = 400;

  typedef struct packed {
    op_e                 op;
    logic [IdW-1:0]      id;
    logic [LenW-1:0]     len;
    logic [PayloadW-1:0] data;
    logic [StampW-1:0]   tick;
  } rx_item_t;

  typedef struct packed {
    rx_item_t item;
    logic     typed;
    result_t  want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  logic                tab_valid   [Entries];
  logic [IdW-1:0]      tab_id      [Entries];
  logic [LenW-1:0]     tab_len     [Entries];
  logic [PayloadW-1:0] tab_payload [Entries];
  logic [StampW-1:0]   tab_stamp   [Entries];

  result_t    reply_q[$];
  result_t    head;
  dir_row_t   plan [NumDir];
  logic [IdW-1:0] pool [PoolSize];
  int         errors = 0;
  int         results_seen = 0;
  int         cyc = 0;
  int         quiet = 0;

  can_rx_last_value_table #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic result_t table_access(input rx_item_t it);
    int hit;
    int slot;
    logic [LenW-1:0] n;
    result_t r;
    n = (it.len > LenW'(FrameBytes)) ? LenW'(FrameBytes) : it.len;
    hit = -1;
    slot = -1;
    r = '0;
    for (int k = 0; k < Entries; k++) begin
      if (hit < 0 && tab_valid[k] && tab_id[k] == it.id) hit = k;
    end
    if (it.op == OP_LOOKUP) begin
      slot = hit;
      if (hit < 0) r.status = ST_MISS;
      else r.status = ST_HIT;
    end else begin
      if (hit >= 0) begin
        slot = hit;
        r.status = ST_UPDATED;
      end else begin
        for (int k = 0; k < Entries; k++) begin
          if (slot < 0 && !tab_valid[k]) slot = k;
        end
        if (slot < 0) r.status = ST_DROPPED;
        else r.status = ST_INSERTED;
      end
      if (slot >= 0) begin
        tab_valid[slot] = 1'b1;
        tab_id[slot] = it.id;
        for (int b = 0; b < FrameBytes; b++) begin
          if (b < n) tab_payload[slot][8*b +: 8] = it.data[8*b +: 8];
        end
        tab_len[slot] = n;
        tab_stamp[slot] = it.tick;
      end
    end
    if (slot >= 0) begin
      r.len = tab_len[slot];
      r.payload = tab_payload[slot];
      r.stamp = tab_stamp[slot];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic offer(input rx_item_t it, input int gap, input logic typed,
                       input result_t want);
    result_t r;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, it.tick, it.data, it.len, it.id};
    s_axis_tuser  <= it.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = table_access(it);
    if (typed) reply_q.push_back(want);
    else reply_q.push_back(r);
    @(negedge clk_i);
  endtask

  initial begin
    rx_item_t it;
    int r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_STORE;
    for (int k = 0; k < Entries; k++) begin
      tab_valid[k]   = 1'b0;
      tab_id[k]      = '0;
      tab_len[k]     = '0;
      tab_payload[k] = '0;
      tab_stamp[k]   = '0;
    end
    for (int k = 0; k < PoolSize; k++) pool[k] = IdW'($urandom_range(0, 2047));

    plan[0]  = '{'{OP_LOOKUP, 11'h000, 4'd0, 64'h0, 32'h0}, 1'b1,
                 '{ST_MISS, 32'h0, 64'h0, 4'd0}};
    plan[1]  = '{'{OP_LOOKUP, 11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                 '{ST_MISS, 32'h0, 64'h0, 4'd0}};
    plan[2]  = '{'{OP_STORE, 11'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                 '{ST_INSERTED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8}};
    plan[3]  = '{'{OP_LOOKUP, 11'h7FF, 4'd0, 64'h0, 32'h0}, 1'b1,
                 '{ST_HIT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8}};
    plan[4]  = '{'{OP_STORE, 11'h000, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0}, 1'b1,
                 '{ST_INSERTED, 32'h0, 64'h0, 4'd0}};
    plan[5]  = '{'{OP_STORE, 11'h000, 4'd15, 64'h8877_6655_4433_2211, 32'h1}, 1'b1,
                 '{ST_UPDATED, 32'h1, 64'h8877_6655_4433_2211, 4'd8}};
    plan[6]  = '{'{OP_STORE, 11'h000, 4'd3, 64'h0, 32'h2}, 1'b0, '0};
    plan[7]  = '{'{OP_STORE, 11'h7FF, 4'd0, 64'h0, 32'h5}, 1'b0, '0};
    plan[8]  = '{'{OP_LOOKUP, 11'h000, 4'd15, 64'h5555_5555_5555_5555, 32'hDEAD_BEEF},
                 1'b0, '0};
    plan[9]  = '{'{OP_STORE, 11'h123, 4'd9, 64'h0123_4567_89AB_CDEF, 32'h8000_0000},
                 1'b0, '0};
    plan[10] = '{'{OP_STORE, 11'h123, 4'd1, 64'h0000_0000_0000_005A, 32'h3}, 1'b0, '0};
    plan[11] = '{'{OP_STORE, 11'h555, 4'd8, 64'hA5A5_5A5A_0F0F_F0F0, 32'h7FFF_FFFF},
                 1'b0, '0};
    plan[12] = '{'{OP_STORE, 11'h2AA, 4'd7, 64'h1122_3344_5566_7788, 32'h0000_FFFF},
                 1'b0, '0};
    plan[13] = '{'{OP_LOOKUP, 11'h456, 4'd8, 64'h0, 32'h0}, 1'b1,
                 '{ST_MISS, 32'h0, 64'h0, 4'd0}};
    plan[14] = '{'{OP_LOOKUP, 11'h123, 4'd0, 64'h0, 32'h0}, 1'b0, '0};
    plan[15] = '{'{OP_STORE, 11'h2AA, 4'd12, 64'hFEDC_BA98_7654_3210, 32'hFFFF_0000},
                 1'b0, '0};
    plan[16] = '{'{OP_LOOKUP, 11'h2AA, 4'd0, 64'h0, 32'h0}, 1'b0, '0};
    plan[17] = '{'{OP_STORE, 11'h7FF, 4'd8, 64'h0, 32'h0}, 1'b1,
                 '{ST_UPDATED, 32'h0, 64'h0, 4'd8}};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDir; i++) offer(plan[i].item, pick_gap(), plan[i].typed, plan[i].want);

    for (int i = 0; i < NumRandom; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) it.op = OP_STORE;
      else it.op = OP_LOOKUP;
      if ($urandom_range(0, 99) < 85) it.id = pool[$urandom_range(0, PoolSize - 1)];
      else it.id = IdW'($urandom);
      if ($urandom_range(0, 99) < 80) it.len = LenW'($urandom_range(0, 8));
      else it.len = LenW'($urandom_range(9, 15));
      it.data = {$urandom, $urandom};
      it.tick = $urandom;
      offer(it, (((i / 64) % 4) == 3) ? 0 : pick_gap(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int hold;
    bit held_off;
    hold = 0;
    held_off = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= HoldOffAt) begin
        hold = HoldOffLen;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else if (((cyc / 256) % 4) == 3 || $urandom_range(0, 99) < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (reply_q.size() == 0) begin
        $error("result transfer with no request pending");
        errors++;
      end else begin
        head = reply_q.pop_front();
        if (head.status !== m_axis_tuser) begin
          $error("status expected %0d got %0d", head.status, m_axis_tuser);
          errors++;
        end
        if (head.len !== m_axis_tdata[3:0]) begin
          $error("stored_len expected %0d got %0d", head.len, m_axis_tdata[3:0]);
          errors++;
        end
        for (int b = 0; b < FrameBytes; b++) begin
          if (head.payload[8*b +: 8] !== m_axis_tdata[4 + 8*b +: 8]) begin
            $error("out_byte%0d expected %0h got %0h", b, head.payload[8*b +: 8],
                   m_axis_tdata[4 + 8*b +: 8]);
            errors++;
          end
        end
        if (head.stamp !== m_axis_tdata[99:68]) begin
          $error("stored_tick expected %0h got %0h", head.stamp, m_axis_tdata[99:68]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

### sim.f
hw/rtl/crlvt_pkg.sv
hw/rtl/can_rx_last_value_table.sv
hw/rtl/crlvt_checker.sv
dv/tb_can_rx_last_value_table.sv
